// ===== rtl/isotp_pkg.sv =====
// Shared types and constants of the ISO-TP receive reassembler.
package isotp_pkg;

	// input item codes
	localparam logic [1:0] CMD_ARM    = 2'd0;
	localparam logic [1:0] CMD_FRAME  = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_CANCEL = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_FLOW    = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b1;
	localparam int CFG_DATA_W = 11;

	localparam logic [7:0] TIMEOUT_RESET = 8'd50;

	// protocol control nibbles
	localparam logic [3:0] PCI_SINGLE = 4'h0;
	localparam logic [3:0] PCI_FIRST  = 4'h1;
	localparam logic [3:0] PCI_CONSEC = 4'h2;

	localparam logic [10:0] ID_LO     = 11'h7E8;
	localparam logic [10:0] ID_HI     = 11'h7EF;
	localparam logic [10:0] FC_OFFSET = 11'd8;

	localparam logic [3:0] DLC_MAX     = 4'd8;
	localparam logic [2:0] CF_MAX_BYTES = 3'd7;
	localparam logic [2:0] FF_BYTES     = 3'd6;

	// lengths and store addresses are carried at the widest first-frame length
	localparam int LEN_W = 12;
	localparam logic [LEN_W-1:0] FF_MIN_LEN = 12'd7;

	localparam logic [9:0] ELAPSED_MAX = 10'h3FF;

	typedef enum logic [1:0] {
		OP_FLOW,
		OP_REPLY,
		OP_TIMEOUT
	} q_op_t;

	typedef struct packed {
		q_op_t             op;
		logic [10:0]       id;
		logic [LEN_W-1:0]  count;
	} q_entry_t;

	typedef struct packed {
		logic             we;
		logic [LEN_W-1:0] addr;
		logic [7:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic reading;
		logic done;
	} back_stat_t;

endpackage

// ===== rtl/isotp_if.sv =====
// Valid/ready channel interfaces for input events and result words.
interface isotp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [10:0] frame_id;
	logic        frame_extended;
	logic        frame_remote;
	logic [3:0]  frame_length;
	logic [63:0] frame_data;

	modport source (output valid, output cmd, output frame_id, output frame_extended,
		output frame_remote, output frame_length, output frame_data, input ready);
	modport sink (input valid, input cmd, input frame_id, input frame_extended,
		input frame_remote, input frame_length, input frame_data, output ready);
endinterface

interface isotp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [10:0] flow_control_id;
	logic [10:0] source_id;
	logic [7:0]  payload_byte;
	logic        last;

	modport source (output valid, output kind, output flow_control_id, output source_id,
		output payload_byte, output last, input ready);
	modport sink (input valid, input kind, input flow_control_id, input source_id,
		input payload_byte, input last, output ready);
endinterface

// ===== rtl/isotp_cmdq.sv =====
// Two-entry command queue between the front and back parts.
module isotp_cmdq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  isotp_pkg::q_entry_t push_entry,
	output logic                pop_valid,
	input  logic                pop_ready,
	output isotp_pkg::q_entry_t pop_entry
);
	import isotp_pkg::*;

	q_entry_t   slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_entry  = slot_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end
endmodule

// ===== rtl/isotp_front.sv =====
// Front part: accepts events, filters and classifies frames, keeps the
// reassembly state and writes payload bytes into the store.
module isotp_front #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	isotp_in_if.sink              in_ch,
	input  logic [10:0]           accept_id,
	input  logic [7:0]            timeout_units,
	output logic                  push_valid,
	input  logic                  push_ready,
	output isotp_pkg::q_entry_t   push_entry,
	output isotp_pkg::mem_wr_t    mem_wr,
	input  isotp_pkg::back_stat_t back_stat
);
	import isotp_pkg::*;

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = $clog2(BUFFER_DEPTH);

	typedef enum logic {ST_IDLE, ST_WRITE} state_t;

	state_t         state_q;
	logic           awaiting_q;
	logic [9:0]     elapsed_q;
	logic [CW-1:0]  stored_q;
	logic [CW-1:0]  expected_q;
	logic [3:0]     seq_q;
	logic [10:0]    src_q;
	logic           reply_out_q;
	logic [55:0]    shreg_q;
	logic [AW-1:0]  waddr_q;
	logic [2:0]     wcnt_q;
	logic           pend_valid_q;
	q_entry_t       pend_q;

	logic           in_acc;
	logic [3:0]     dlc;
	logic [3:0]     pci;
	logic [3:0]     nib;
	logic [LEN_W-1:0] ff_len;
	logic           id_ok;
	logic           frame_ok;
	logic           is_sf;
	logic           is_ff;
	logic           ff_big;
	logic           is_cf;
	logic [CW-1:0]  cf_rem;
	logic [2:0]     cf_n;
	logic [CW-1:0]  cf_sum;
	logic           cf_done;
	logic [9:0]     elapsed_inc;
	logic           tick_hit;

	assign in_ch.ready = (state_q == ST_IDLE) && !reply_out_q && push_ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_comb begin
		dlc = (in_ch.frame_length > DLC_MAX) ? DLC_MAX : in_ch.frame_length;
		pci = in_ch.frame_data[7:4];
		nib = in_ch.frame_data[3:0];
		ff_len = {nib, in_ch.frame_data[15:8]};
		if (accept_id != 11'd0)
			id_ok = (in_ch.frame_id == accept_id);
		else
			id_ok = (in_ch.frame_id >= ID_LO) && (in_ch.frame_id <= ID_HI);
		frame_ok = awaiting_q && !in_ch.frame_extended && !in_ch.frame_remote &&
			(in_ch.frame_length != 4'd0) && id_ok;
		is_sf  = frame_ok && (pci == PCI_SINGLE) && (nib <= dlc - 4'd1);
		is_ff  = frame_ok && (pci == PCI_FIRST) && (dlc == DLC_MAX) && (ff_len >= FF_MIN_LEN);
		ff_big = (ff_len > LEN_W'(BUFFER_DEPTH));
		is_cf  = frame_ok && (pci == PCI_CONSEC) && (expected_q != '0) && (nib == seq_q);
		cf_rem  = expected_q - stored_q;
		cf_n    = (cf_rem > CW'(CF_MAX_BYTES)) ? CF_MAX_BYTES : cf_rem[2:0];
		cf_sum  = stored_q + CW'(cf_n);
		cf_done = (cf_sum >= expected_q);
		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 10'd1;
		tick_hit    = (elapsed_inc >= {timeout_units, 2'b00});
	end

	// results with no store writes go out at once, the rest with the last write
	always_comb begin
		push_valid = 1'b0;
		push_entry = pend_q;
		if (state_q == ST_WRITE) begin
			push_valid = (wcnt_q == 3'd1) && pend_valid_q;
		end else if (in_acc) begin
			if (in_ch.cmd == CMD_TICK && awaiting_q && tick_hit) begin
				push_valid = 1'b1;
				push_entry = '{op: OP_TIMEOUT, id: 11'd0, count: '0};
			end else if (in_ch.cmd == CMD_FRAME && is_sf && nib == 4'd0) begin
				push_valid = 1'b1;
				push_entry = '{op: OP_REPLY, id: in_ch.frame_id, count: '0};
			end
		end
	end

	assign mem_wr = '{we: (state_q == ST_WRITE), addr: LEN_W'(waddr_q), data: shreg_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			awaiting_q   <= 1'b0;
			elapsed_q    <= '0;
			stored_q     <= '0;
			expected_q   <= '0;
			seq_q        <= '0;
			src_q        <= '0;
			reply_out_q  <= 1'b0;
			shreg_q      <= '0;
			waddr_q      <= '0;
			wcnt_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
		end else begin
			if (push_valid && push_entry.op == OP_REPLY && push_entry.count != '0)
				reply_out_q <= 1'b1;
			else if (back_stat.done)
				reply_out_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.cmd)
							CMD_ARM: begin
								stored_q   <= '0;
								expected_q <= '0;
								seq_q      <= '0;
								elapsed_q  <= '0;
								awaiting_q <= 1'b1;
							end
							CMD_FRAME: begin
								priority if (is_sf) begin
									stored_q     <= CW'(nib);
									src_q        <= in_ch.frame_id;
									awaiting_q   <= 1'b0;
									shreg_q      <= in_ch.frame_data[63:8];
									waddr_q      <= '0;
									wcnt_q       <= nib[2:0];
									pend_valid_q <= 1'b1;
									pend_q       <= '{op: OP_REPLY, id: in_ch.frame_id,
										count: LEN_W'(nib)};
									if (nib != 4'd0)
										state_q <= ST_WRITE;
								end else if (is_ff && ff_big) begin
									awaiting_q <= 1'b0;
								end else if (is_ff) begin
									expected_q   <= CW'(ff_len);
									stored_q     <= CW'(FF_BYTES);
									src_q        <= in_ch.frame_id;
									seq_q        <= 4'd1;
									shreg_q      <= {8'd0, in_ch.frame_data[63:16]};
									waddr_q      <= '0;
									wcnt_q       <= FF_BYTES;
									pend_valid_q <= 1'b1;
									pend_q       <= '{op: OP_FLOW, id: in_ch.frame_id, count: '0};
									state_q      <= ST_WRITE;
								end else if (is_cf) begin
									stored_q     <= cf_sum;
									seq_q        <= seq_q + 4'd1;
									shreg_q      <= in_ch.frame_data[63:8];
									waddr_q      <= stored_q[AW-1:0];
									wcnt_q       <= cf_n;
									pend_valid_q <= cf_done;
									pend_q       <= '{op: OP_REPLY, id: src_q,
										count: LEN_W'(cf_sum)};
									if (cf_done)
										awaiting_q <= 1'b0;
									state_q      <= ST_WRITE;
								end else begin
									// drop the frame
								end
							end
							CMD_TICK: begin
								if (awaiting_q) begin
									elapsed_q <= elapsed_inc;
									if (tick_hit)
										awaiting_q <= 1'b0;
								end
							end
							CMD_CANCEL: begin
								awaiting_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_WRITE: begin
					shreg_q <= {8'd0, shreg_q[55:8]};
					waddr_q <= waddr_q + AW'(1);
					wcnt_q  <= wcnt_q - 3'd1;
					if (wcnt_q == 3'd1)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/isotp_back.sv =====
// Back part: holds the reply store, turns queued commands into result words
// and streams a stored reply one byte per word.
module isotp_back #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  isotp_pkg::q_entry_t   pop_entry,
	input  isotp_pkg::mem_wr_t    mem_wr,
	output isotp_pkg::back_stat_t back_stat,
	isotp_out_if.source           out_ch
);
	import isotp_pkg::*;

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [7:0]    store_mem [BUFFER_DEPTH];

	logic          busy_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [10:0]   src_q;
	logic          rd_valid_s1;
	logic          rd_last_s1;
	logic [7:0]    rd_data_s1;

	logic          out_valid_q;
	logic [1:0]    kind_q;
	logic [10:0]   fc_id_q;
	logic [10:0]   src_id_q;
	logic [7:0]    byte_q;
	logic          last_q;

	logic          out_free;
	logic          load_byte;
	logic          rd_en;
	logic          rd_last;
	logic          is_stream;
	logic          pop;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign load_byte = rd_valid_s1 && out_free;
	assign rd_en     = busy_q && (!rd_valid_s1 || load_byte);
	assign rd_last   = (idx_q == cnt_q - CW'(1));
	assign is_stream = (pop_entry.op == OP_REPLY) && (pop_entry.count != '0);
	// take a command only once the previous reply has fully left the read stage
	assign pop_ready = !busy_q && !rd_valid_s1 && (is_stream || out_free);
	assign pop       = pop_valid && pop_ready;

	assign back_stat = '{reading: busy_q, done: rd_en && rd_last};

	assign out_ch.valid           = out_valid_q;
	assign out_ch.kind            = kind_q;
	assign out_ch.flow_control_id = fc_id_q;
	assign out_ch.source_id       = src_id_q;
	assign out_ch.payload_byte    = byte_q;
	assign out_ch.last            = last_q;

	always_ff @(posedge clk) begin
		if (mem_wr.we)
			store_mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
		if (rd_en)
			rd_data_s1 <= store_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_last_s1 <= rd_last;
		if (load_byte) begin
			kind_q   <= KIND_BYTE;
			fc_id_q  <= 11'd0;
			src_id_q <= src_q;
			byte_q   <= rd_data_s1;
			last_q   <= rd_last_s1;
		end else if (pop && !is_stream) begin
			fc_id_q <= 11'd0;
			byte_q  <= 8'd0;
			last_q  <= 1'b1;
			unique case (pop_entry.op)
				OP_FLOW: begin
					kind_q   <= KIND_FLOW;
					fc_id_q  <= pop_entry.id - FC_OFFSET;
					src_id_q <= pop_entry.id;
				end
				OP_REPLY: begin
					kind_q   <= KIND_EMPTY;
					src_id_q <= pop_entry.id;
				end
				default: begin
					kind_q   <= KIND_TIMEOUT;
					src_id_q <= 11'd0;
				end
			endcase
		end
		if (pop && is_stream) begin
			cnt_q <= CW'(pop_entry.count);
			src_q <= pop_entry.id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && is_stream) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CW'(1);
				if (rd_last)
					busy_q <= 1'b0;
			end

			if (rd_en)
				rd_valid_s1 <= 1'b1;
			else if (load_byte)
				rd_valid_s1 <= 1'b0;

			if (load_byte || (pop && !is_stream))
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== rtl/iso_tp_receive_reassembler.sv =====
// ISO-TP receive reassembler: events in, flow-control/reply/timeout words out.
// A frame carrying payload bytes keeps the front busy, refusing input, while it
// writes them into the store. Result words leave from an output register; a reply
// of N bytes streams at one byte a cycle while the output is ready, and input is
// held off until the last byte is read out.
// Reset clears all control state; store contents stay undefined, no clearing pass.
module iso_tp_receive_reassembler #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	isotp_in_if.sink                             in_ch,
	isotp_out_if.source                          out_ch,
	input  logic                                 cfg_we,
	input  logic [isotp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [isotp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import isotp_pkg::*;

	logic [10:0] accept_id_q;
	logic [7:0]  timeout_q;

	logic        push_valid;
	logic        push_ready;
	q_entry_t    push_entry;
	logic        pop_valid;
	logic        pop_ready;
	q_entry_t    pop_entry;
	mem_wr_t     mem_wr;
	back_stat_t  back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_id_q <= 11'd0;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACCEPT_ID: accept_id_q <= cfg_wdata[10:0];
				REG_TIMEOUT:   timeout_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	isotp_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.accept_id     (accept_id_q),
		.timeout_units (timeout_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_entry    (push_entry),
		.mem_wr        (mem_wr),
		.back_stat     (back_stat)
	);

	isotp_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	isotp_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.mem_wr    (mem_wr),
		.back_stat (back_stat),
		.out_ch    (out_ch)
	);

	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("command pushed into a full queue");

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.we |-> !back_stat.reading)
		else $error("store written while a reply is being read");

	a_done_ends_read: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.done |=> !back_stat.reading)
		else $error("reply read still running after its last byte");

	a_fc_id_only_on_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.kind != KIND_FLOW) |-> (out_ch.flow_control_id == 11'd0))
		else $error("flow control id set on a non flow-control word");
endmodule
